// ===== design/assert_macros.svh =====
// Assertion macros shared by the mutex node RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while arst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

// ===== design/dmn_pkg.sv =====
// Shared types, constants and helper functions of the mutex node.
`timescale 1ns / 1ps
`default_nettype none

package dmn_pkg;

	localparam int NODES      = 16;
	localparam int CLOCK_BITS = 32;

	localparam int ID_W    = 4;
	localparam int CNT_W   = 5;
	localparam int STAMP_W = 32;
	localparam int DEF_AW  = 4;
	localparam int DEF_DEPTH = 1 << DEF_AW;

	typedef logic [ID_W-1:0]       id_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CLOCK_BITS-1:0] clk_t;
	typedef logic [STAMP_W-1:0]    stamp_t;
	typedef logic [DEF_AW-1:0]     dcnt_t;

	localparam cnt_t  MAX_CNT   = cnt_t'((NODES < 16) ? NODES : 16);
	localparam dcnt_t DEFER_CAP = dcnt_t'(15);
	localparam clk_t  CLK_MAX   = '1;

	typedef enum logic [1:0] {
		OP_MSG     = 2'd0,
		OP_ENTER   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_FINISH  = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		OUT_REQUEST = 1'b0,
		OUT_ACK     = 1'b1
	} out_kind_t;

	typedef enum logic [0:0] {
		REG_NODE_ID    = 1'b0,
		REG_NODE_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REQ  = 2'd1,
		MODE_CS   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		EMIT_NOP   = 2'd0,
		EMIT_ACK   = 2'd1,
		EMIT_BCAST = 2'd2,
		EMIT_DEFER = 2'd3
	} emit_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RX_REQ,
		ST_RX_ACK,
		ST_EMIT_NOP,
		ST_EMIT_IGN,
		ST_EMIT_ACK,
		ST_BCAST,
		ST_FL_RD,
		ST_FL_OUT
	} state_t;

	typedef struct packed {
		id_t    id;
		stamp_t stamp;
	} def_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_in;
		logic      clk_merge;
		logic      clk_bump;
		logic      start_req;
		logic      enter_cs;
		logic      ack_dec;
		logic      go_idle;
		logic      defer_push;
		logic      def_clear;
		logic      def_read;
		logic      idx_clear;
		logic      idx_inc;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
		logic      emit_ign;
	} dmn_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic [1:0] kind;
		mode_t      mode;
		logic       acks_zero;
		logic       acks_one;
		logic       defer_full;
		logic       def_empty;
		logic       sender_first;
		logic       id_in_range;
		logic       cnt_one;
		logic       bc_skip;
		logic       bc_last;
		logic       fl_last;
		logic       out_free;
	} dmn_status_t;

	// Saturating increment of the Lamport clock.
	function automatic clk_t clk_inc(clk_t c);
		return (c == CLK_MAX) ? c : c + clk_t'(1);
	endfunction

	// A received stamp, clamped to the clock range.
	function automatic clk_t clk_from_msg(stamp_t m);
		stamp_t lim;
		lim = STAMP_W'(CLK_MAX);
		return (m > lim) ? CLK_MAX : CLOCK_BITS'(m);
	endfunction

	// Stamp carried by an outgoing message: the low bits of the clock.
	function automatic stamp_t clk_out(clk_t c);
		return STAMP_W'(c);
	endfunction

endpackage

`default_nettype wire

// ===== design/dmn_ctrl.sv =====
// Controller state machine of the mutex node: sequences each transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dmn_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  dmn_pkg::dmn_status_t status,
	output dmn_pkg::dmn_cmd_t   cmd
);
	import dmn_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.op)
					OP_MSG: begin
						if (status.kind inside {KIND_REQUEST, KIND_ACK, KIND_FINISH}) begin
							cmd.clk_merge = 1'b1;
						end
						case (status.kind)
							KIND_REQUEST: state_d = ST_RX_REQ;
							KIND_ACK:     state_d = ST_RX_ACK;
							KIND_FINISH:  state_d = ST_EMIT_NOP;
							default:      state_d = ST_EMIT_IGN;
						endcase
					end
					OP_ENTER: begin
						if (status.mode != MODE_IDLE || !status.id_in_range) begin
							state_d = ST_EMIT_IGN;
						end else begin
							cmd.clk_bump  = 1'b1;
							cmd.start_req = 1'b1;
							cmd.idx_clear = 1'b1;
							if (status.cnt_one) begin
								cmd.enter_cs = 1'b1;
								state_d      = ST_EMIT_NOP;
							end else begin
								state_d = ST_BCAST;
							end
						end
					end
					OP_RELEASE: begin
						if (status.mode != MODE_CS) begin
							state_d = ST_EMIT_IGN;
						end else begin
							cmd.clk_bump  = 1'b1;
							cmd.go_idle   = 1'b1;
							cmd.idx_clear = 1'b1;
							state_d       = status.def_empty ? ST_EMIT_NOP : ST_FL_RD;
						end
					end
					default: state_d = ST_EMIT_IGN;
				endcase
			end
			ST_RX_REQ: begin
				if (status.mode == MODE_IDLE ||
				    (status.mode == MODE_REQ && status.sender_first)) begin
					cmd.clk_bump = 1'b1;
					state_d      = ST_EMIT_ACK;
				end else if (status.defer_full) begin
					state_d = ST_EMIT_IGN;
				end else begin
					cmd.defer_push = 1'b1;
					state_d        = ST_EMIT_NOP;
				end
			end
			ST_RX_ACK: begin
				if (status.mode != MODE_REQ || status.acks_zero) begin
					state_d = ST_EMIT_IGN;
				end else begin
					cmd.ack_dec  = 1'b1;
					cmd.enter_cs = status.acks_one;
					state_d      = ST_EMIT_NOP;
				end
			end
			ST_EMIT_NOP, ST_EMIT_IGN, ST_EMIT_ACK: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_ign  = (state_q == ST_EMIT_IGN);
					cmd.emit_sel  = (state_q == ST_EMIT_ACK) ? EMIT_ACK : EMIT_NOP;
					state_d       = ST_IDLE;
				end
			end
			ST_BCAST: begin
				if (status.bc_skip) begin
					cmd.idx_inc = 1'b1;
				end else if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EMIT_BCAST;
					cmd.emit_last = status.bc_last;
					cmd.idx_inc   = 1'b1;
					if (status.bc_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FL_RD: begin
				cmd.def_read = 1'b1;
				state_d      = ST_FL_OUT;
			end
			ST_FL_OUT: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EMIT_DEFER;
					cmd.emit_last = status.fl_last;
					cmd.idx_inc   = 1'b1;
					if (status.fl_last) begin
						cmd.def_clear = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_FL_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_RST(a_emit_into_free, cmd.emit |-> status.out_free, "result loaded into a full output register")
	`ASSERT_RST(a_last_ends_item, (cmd.emit && cmd.emit_last) |=> (state_q == ST_IDLE), "final result did not end the transaction")

endmodule

`default_nettype wire

// ===== design/dmn_dp.sv =====
// Datapath of the mutex node: protocol state, deferred-ack store and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dmn_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dmn_pkg::dmn_cmd_t    cmd,
	output dmn_pkg::dmn_status_t status,
	input  wire  [1:0]           in_op,
	input  wire  [1:0]           in_kind,
	input  wire  [dmn_pkg::ID_W-1:0]    in_src,
	input  wire  [dmn_pkg::STAMP_W-1:0] in_stamp,
	input  wire                  cfg_wr,
	input  wire  [0:0]           cfg_index,
	input  wire  [dmn_pkg::CNT_W-1:0]   cfg_data,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic                 out_send,
	output logic [dmn_pkg::ID_W-1:0]    out_dest,
	output logic                 out_kind,
	output logic [dmn_pkg::STAMP_W-1:0] out_stamp,
	output logic                 out_last,
	output logic                 out_in_section,
	output logic                 out_ignored
);
	import dmn_pkg::*;

	id_t        node_id_q;
	cnt_t       node_count_q;
	logic [1:0] in_op_q;
	logic [1:0] in_kind_q;
	id_t        in_src_q;
	clk_t       in_clk_q;
	mode_t      mode_q;
	clk_t       clock_q;
	clk_t       req_date_q;
	id_t        acks_q;
	dcnt_t      dcount_q;
	id_t        idx_q;
	def_entry_t def_mem [DEF_DEPTH];
	def_entry_t rd_q;
	logic       out_valid_q;
	cnt_t       cnt_eff;
	id_t        cnt_m1;
	id_t        bc_last_idx;
	clk_t       merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q    <= '0;
			node_count_q <= cnt_t'(2);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_NODE_ID:    node_id_q    <= cfg_data[ID_W-1:0];
				REG_NODE_COUNT: node_count_q <= cfg_data;
				default:        node_id_q    <= node_id_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_op_q   <= in_op;
			in_kind_q <= in_kind;
			in_src_q  <= in_src;
			in_clk_q  <= clk_from_msg(in_stamp);
		end
	end

	always_comb begin
		if (node_count_q > MAX_CNT) begin
			cnt_eff = MAX_CNT;
		end else if (node_count_q == '0) begin
			cnt_eff = cnt_t'(1);
		end else begin
			cnt_eff = node_count_q;
		end
		cnt_m1      = ID_W'(cnt_eff - cnt_t'(1));
		bc_last_idx = (cnt_m1 == node_id_q) ? cnt_m1 - id_t'(1) : cnt_m1;
		merged      = clk_inc((clock_q > in_clk_q) ? clock_q : in_clk_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			clock_q    <= '0;
			req_date_q <= '0;
			acks_q     <= '0;
			dcount_q   <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.clk_merge) begin
				clock_q <= merged;
			end else if (cmd.clk_bump) begin
				clock_q <= clk_inc(clock_q);
			end
			if (cmd.start_req) begin
				req_date_q <= clk_inc(clock_q);
			end
			if (cmd.enter_cs) begin
				mode_q <= MODE_CS;
			end else if (cmd.start_req) begin
				mode_q <= MODE_REQ;
			end else if (cmd.go_idle) begin
				mode_q <= MODE_IDLE;
			end
			if (cmd.start_req) begin
				acks_q <= cnt_m1;
			end else if (cmd.ack_dec) begin
				acks_q <= acks_q - id_t'(1);
			end
			if (cmd.def_clear) begin
				dcount_q <= '0;
			end else if (cmd.defer_push) begin
				dcount_q <= dcount_q + dcnt_t'(1);
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + id_t'(1);
			end
		end
	end

	// Deferred acks: sender and the clock at the time the request was held back.
	always_ff @(posedge clk) begin
		if (cmd.defer_push) begin
			def_mem[dcount_q] <= '{id: in_src_q, stamp: clk_out(clock_q)};
		end
		if (cmd.def_read) begin
			rd_q <= def_mem[idx_q[DEF_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last       <= cmd.emit_last;
			out_ignored    <= cmd.emit_ign;
			out_in_section <= (mode_q == MODE_CS);
			case (cmd.emit_sel)
				EMIT_ACK: begin
					out_send  <= 1'b1;
					out_dest  <= in_src_q;
					out_kind  <= OUT_ACK;
					out_stamp <= clk_out(clock_q);
				end
				EMIT_BCAST: begin
					out_send  <= 1'b1;
					out_dest  <= idx_q;
					out_kind  <= OUT_REQUEST;
					out_stamp <= clk_out(clock_q);
				end
				EMIT_DEFER: begin
					out_send  <= 1'b1;
					out_dest  <= rd_q.id;
					out_kind  <= OUT_ACK;
					out_stamp <= rd_q.stamp;
				end
				default: begin
					out_send  <= 1'b0;
					out_dest  <= '0;
					out_kind  <= OUT_REQUEST;
					out_stamp <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.op           = in_op_q;
		status.kind         = in_kind_q;
		status.mode         = mode_q;
		status.acks_zero    = (acks_q == '0);
		status.acks_one     = (acks_q == id_t'(1));
		status.defer_full   = (dcount_q >= DEFER_CAP);
		status.def_empty    = (dcount_q == '0);
		status.sender_first = (in_clk_q < req_date_q) ||
		                      (in_clk_q == req_date_q && in_src_q < node_id_q);
		status.id_in_range  = ({1'b0, node_id_q} < cnt_eff);
		status.cnt_one      = (cnt_eff == cnt_t'(1));
		status.bc_skip      = (idx_q == node_id_q);
		status.bc_last      = (idx_q == bc_last_idx);
		status.fl_last      = (idx_q[DEF_AW-1:0] == dcount_q - dcnt_t'(1));
		status.out_free     = !out_valid_q || out_ready;
	end

	`ASSERT_RST(a_cs_no_acks, (mode_q != MODE_CS) || (acks_q == '0), "in section with acks outstanding")
	`ASSERT_RST(a_defer_not_idle, cmd.defer_push |-> (mode_q != MODE_IDLE), "request deferred while idle")

endmodule

`default_nettype wire

// ===== design/distributed_mutex_node_core.sv =====
// Top level of one Ricart-Agrawala mutual exclusion node with a Lamport clock.
`timescale 1ns / 1ps
`default_nettype none

// One node of Ricart-Agrawala mutual exclusion. Each input transaction is a
// received protocol message (request, ack or finish), a local request to enter
// the critical section, or a local release; each produces one or more result
// transactions, the final one marked by m_axis_tlast. Results with send_valid
// set are messages to forward to node dest_id; a transaction that sends nothing
// yields a single result with send_valid clear. Every result also reports
// whether the node holds the section and whether the input was ignored.
// The node handles one input at a time. A received message or an ignored
// input passes dispatch, a receive state for requests and acks, and an emit
// state before its result is registered. A request to enter broadcasts one
// request per other node, one per cycle while the output register is free,
// and passes over this node's own id. A release plays back the deferred acks
// from a small internal store whose read is registered, so each deferred ack
// passes a read state and an output state. The final result sits in an output
// register, so the next input transaction is accepted while it waits to be
// taken. Configuration (node_id at index 0, node_count at index 1) is always
// accepted and must be written only while the node is idle.

module distributed_mutex_node_core (
	input  wire         clk,
	input  wire         arst_n,
	// Input: tdata = sender_id[3:0], msg_clock[35:4], zero fill [39:36].
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,
	// Input: tuser = op[1:0], msg_kind[3:2].
	input  wire  [3:0]  s_axis_tuser,
	// Output: tdata = dest_id[3:0], out_clock[35:4], in_section[36], zero fill [39:37].
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,
	// Output: tuser = send_valid[0], out_kind[1], ignored[2].
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	// Configuration write channel.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_index,
	input  wire  [4:0]  cfg_data
);
	import dmn_pkg::*;

	dmn_cmd_t    cmd;
	dmn_status_t status;
	logic        out_send;
	id_t         out_dest;
	logic        out_kind;
	stamp_t      out_stamp;
	logic        out_in_section;
	logic        out_ignored;

	// Registers are simple flops, so a write is taken in any cycle.
	assign cfg_ready = 1'b1;

	dmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dmn_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_op          (s_axis_tuser[1:0]),
		.in_kind        (s_axis_tuser[3:2]),
		.in_src         (s_axis_tdata[3:0]),
		.in_stamp       (s_axis_tdata[35:4]),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_send       (out_send),
		.out_dest       (out_dest),
		.out_kind       (out_kind),
		.out_stamp      (out_stamp),
		.out_last       (m_axis_tlast),
		.out_in_section (out_in_section),
		.out_ignored    (out_ignored)
	);

	assign m_axis_tdata = {3'b000, out_in_section, out_stamp, out_dest};
	assign m_axis_tuser = {out_ignored, out_kind, out_send};

endmodule

`default_nettype wire
